// ===== hw/rtl/bmbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmbs_pkg
// shared types and constants of the brushed motor bridge sequencer
// ----------------------------------------------------------------------------
package bmbs_pkg;

    localparam int SPEED_W    = 16;
    localparam int TIME_W     = 32;
    localparam int DUTY_W     = 15;
    localparam int DEADTIME_W = 20;
    localparam int BRAKE_W    = 2;
    localparam int THRESH_W   = 15;

    localparam logic [DUTY_W-1:0] FULL_DUTY = 15'h7fff;

    // register indexes on the configuration port
    localparam logic [1:0] REG_PARAMS_VALID   = 2'd0;
    localparam logic [1:0] REG_DEAD_TIME      = 2'd1;
    localparam logic [1:0] REG_STOP_DRIVE     = 2'd2;
    localparam logic [1:0] REG_ZERO_THRESHOLD = 2'd3;

    // stop drive codes
    localparam logic [BRAKE_W-1:0] BRAKE_COAST = 2'd0;
    localparam logic [BRAKE_W-1:0] BRAKE_LOW   = 2'd1;
    localparam logic [BRAKE_W-1:0] BRAKE_HIGH  = 2'd2;

    // overall status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PAUSE = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_cmd;
        logic        [TIME_W-1:0]  now_us;
        logic                      bridge_fault;
    } cmd_t;

    typedef struct packed {
        logic              drive_valid;
        logic [DUTY_W-1:0] high_duty_a;
        logic              low_on_a;
        logic [DUTY_W-1:0] high_duty_b;
        logic              low_on_b;
        logic [1:0]        mode_now;
        logic              err_no_params;
        logic              err_bridge;
        logic [1:0]        overall_status;
    } drv_t;

    typedef struct packed {
        logic                  params_valid;
        logic [DEADTIME_W-1:0] dead_time;
        logic [BRAKE_W-1:0]    stop_drive;
        logic [THRESH_W-1:0]   zero_threshold;
    } cfg_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [SPEED_W-1:0] prev_speed;
        logic        [TIME_W-1:0]  pause_start_us;
        logic                      err_no_params;
        logic                      err_bridge;
    } state_t;

endpackage

// ===== hw/rtl/bmbs_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmbs_cmd_if
// speed command channel: valid, ready and one command request
// ----------------------------------------------------------------------------
interface bmbs_cmd_if
    import bmbs_pkg::*;
;
    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bmbs_drv_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmbs_drv_if
// bridge drive channel: valid, ready and one drive/status request
// ----------------------------------------------------------------------------
interface bmbs_drv_if
    import bmbs_pkg::*;
;
    logic valid;
    logic ready;
    drv_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bmbs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmbs_step
// one sequencer step: next mode, bridge drive and error flags for a command
// ----------------------------------------------------------------------------
module bmbs_step
    import bmbs_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t state_cur,
    input  cmd_t   cmd,
    output state_t state_next,
    output drv_t   drv
);

    logic signed [SPEED_W-1:0] spd;
    logic [SPEED_W-1:0]        spd_mag;
    logic                      near_zero;
    logic                      reversal;
    logic [TIME_W-1:0]         elapsed;
    logic                      pause_done;
    mode_t                     want;
    mode_t                     mode_new;
    logic                      err_np;
    logic                      err_br;

    assign spd     = cmd.speed_cmd;
    // most negative speed gives 32768, which is fine as an unsigned magnitude
    assign spd_mag = spd[SPEED_W-1] ? SPEED_W'(~spd + 1'b1) : SPEED_W'(spd);
    assign near_zero = spd_mag < {1'b0, cfg.zero_threshold};
    assign reversal  = ((spd > 0) && (state_cur.prev_speed < 0))
                    || ((spd < 0) && (state_cur.prev_speed > 0));
    assign elapsed    = cmd.now_us - state_cur.pause_start_us;
    assign pause_done = elapsed >= {{(TIME_W-DEADTIME_W){1'b0}}, cfg.dead_time};

    always_comb
    begin
        unique case (state_cur.mode)
            MODE_STOP:
            begin
                want = (spd != 0) ? MODE_RUN : MODE_STOP;
            end
            MODE_RUN:
            begin
                if (near_zero)
                    want = MODE_STOP;
                else if (reversal && (cfg.dead_time != '0))
                    want = MODE_PAUSE;
                else
                    want = MODE_RUN;
            end
            MODE_PAUSE:
            begin
                if (near_zero)
                    want = MODE_STOP;
                else if (pause_done)
                    want = MODE_RUN;
                else
                    want = MODE_PAUSE;
            end
            default:
            begin
                want = state_cur.mode;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_cur;
        mode_new   = state_cur.mode;
        err_np     = 1'b1;
        err_br     = state_cur.err_bridge;

        drv             = '0;

        if (cfg.params_valid)
        begin
            err_np   = 1'b0;
            mode_new = want;
            if (want != state_cur.mode)
                state_next.pause_start_us = (want == MODE_RUN) ? '0 : cmd.now_us;
            state_next.mode = want;

            drv.drive_valid = 1'b1;
            unique case (want)
                MODE_STOP:
                begin
                    if (cfg.stop_drive == BRAKE_LOW)
                    begin
                        drv.low_on_a = 1'b1;
                        drv.low_on_b = 1'b1;
                    end
                    else if (cfg.stop_drive == BRAKE_HIGH)
                    begin
                        drv.high_duty_a = FULL_DUTY;
                        drv.high_duty_b = FULL_DUTY;
                    end
                end
                MODE_RUN:
                begin
                    if (spd > 0)
                    begin
                        drv.high_duty_a = spd[DUTY_W-1:0];
                        drv.low_on_b    = 1'b1;
                    end
                    else
                    begin
                        drv.low_on_a    = 1'b1;
                        drv.high_duty_b = spd_mag[DUTY_W] ? FULL_DUTY : spd_mag[DUTY_W-1:0];
                    end
                end
                default:
                begin
                    // pause: bridge floats
                end
            endcase

            if (cmd.bridge_fault)
                err_br = 1'b1;
            else
            begin
                err_br                = 1'b0;
                state_next.prev_speed = spd;
            end
        end

        state_next.err_no_params = err_np;
        state_next.err_bridge    = err_br;
        drv.mode_now       = mode_new;
        drv.err_no_params  = err_np;
        drv.err_bridge     = err_br;
        drv.overall_status = (err_np || err_br) ? STATUS_ERROR : STATUS_OK;
    end

endmodule

// ===== hw/rtl/brushed_motor_bridge_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brushed_motor_bridge_sequencer_top
// h-bridge sequencer for a brushed dc motor with dead time on reversal
// ----------------------------------------------------------------------------
// usage
//   cmd : speed command requests (speed_cmd, now_us, bridge_fault), valid/ready
//   drv : one drive/status request per command, valid/ready
//   apb : four registers at byte addresses 0, 4, 8, 12 (params valid,
//         dead time, stop drive, zero threshold); write only while idle
// timing
//   a command is captured in an input register, and the step logic is
//   combinational between that register and the output register, which
//   drives drv; with drv ready one command per clock is sustained; the
//   sequencer state updates in the same cycle the step result is loaded
//   into the output register
// reset
//   mode stop, last speed zero, pause timer zero, error flags clear;
//   registers zero except zero_threshold which comes up as 1
// stall
//   while drv is stalled the output holds; one more command sits in the
//   input register, then cmd.ready drops until the output drains
// ----------------------------------------------------------------------------
module brushed_motor_bridge_sequencer_top
    import bmbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bmbs_cmd_if.sink    cmd,
    bmbs_drv_if.source  drv,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic                  params_valid_reg;
    logic [DEADTIME_W-1:0] deadtime_reg;
    logic [BRAKE_W-1:0]    stop_drive_reg;
    logic [THRESH_W-1:0]   zero_thr_reg;
    logic                  cfg_wr;
    cfg_t                  cfg;

    // pipeline
    logic   in_valid_reg;
    cmd_t   in_data_reg;
    logic   out_valid_reg;
    drv_t   out_data_reg;
    logic   advance;
    logic   in_take;

    // sequencer state
    state_t state_reg;
    state_t state_next;
    drv_t   step_drv;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            params_valid_reg <= 1'b0;
            deadtime_reg     <= '0;
            stop_drive_reg   <= BRAKE_COAST;
            zero_thr_reg     <= THRESH_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PARAMS_VALID:   params_valid_reg <= pwdata[0];
                REG_DEAD_TIME:      deadtime_reg     <= pwdata[DEADTIME_W-1:0];
                REG_STOP_DRIVE:     stop_drive_reg   <= pwdata[BRAKE_W-1:0];
                REG_ZERO_THRESHOLD: zero_thr_reg     <= pwdata[THRESH_W-1:0];
                default:            ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_PARAMS_VALID:   prdata = {31'b0, params_valid_reg};
            REG_DEAD_TIME:      prdata = {{(32-DEADTIME_W){1'b0}}, deadtime_reg};
            REG_STOP_DRIVE:     prdata = {{(32-BRAKE_W){1'b0}}, stop_drive_reg};
            REG_ZERO_THRESHOLD: prdata = {{(32-THRESH_W){1'b0}}, zero_thr_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.params_valid   = params_valid_reg;
    assign cfg.dead_time      = deadtime_reg;
    assign cfg.stop_drive     = stop_drive_reg;
    assign cfg.zero_threshold = zero_thr_reg;

    // the input register moves on when the output register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || drv.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign in_take   = cmd.valid && cmd.ready;

    bmbs_step u_step (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .cmd        (in_data_reg),
        .state_next (state_next),
        .drv        (step_drv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_STOP, prev_speed: '0, pause_start_us: '0,
                               err_no_params: 1'b0, err_bridge: 1'b0};
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (drv.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= cmd.payload;
        if (advance)
            out_data_reg <= step_drv;
    end

    assign drv.valid   = out_valid_reg;
    assign drv.payload = out_data_reg;

    // checks

    // a waiting command is never dropped while the output is stalled
    a_hold_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending command lost");

    // sequencer state only moves with a step
    a_state_step: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a step");

    // a presented result reports the mode the sequencer now holds
    a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(advance) && out_valid_reg) |-> (out_data_reg.mode_now == state_reg.mode))
        else $error("reported mode differs from state");

    // a pause result floats the bridge
    a_pause_float: assert property (@(posedge clk) disable iff (!rst_n)
        (drv.valid && (drv.payload.mode_now == MODE_PAUSE) && drv.payload.drive_valid)
        |-> (drv.payload.high_duty_a == '0 && drv.payload.high_duty_b == '0
             && !drv.payload.low_on_a && !drv.payload.low_on_b))
        else $error("bridge driven during pause");

    // missing parameters never come with an applied drive
    a_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        drv.valid |-> !(drv.payload.drive_valid && drv.payload.err_no_params))
        else $error("drive applied without parameters");

endmodule

// ===== dv/brushed_motor_bridge_sequencer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brushed_motor_bridge_sequencer_top_test
// self-checking bench for the h-bridge sequencer: a directed walk through
// brake modes, dead-time reversal, saturation and error flags, then random
// command sequences under several register settings, with bursty commands
// and a stalling drive sink, each drive request checked field by field
// ----------------------------------------------------------------------------
module brushed_motor_bridge_sequencer_top_test;
    import bmbs_pkg::*;

    // brake code with no name in the package, behaves like coast
    localparam logic [BRAKE_W-1:0] BRAKE_UNUSED = 2'd3;

    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int CYCLE_LIMIT     = 500_000;
    localparam int PRINT_CAP       = 100;

    typedef enum logic
    {
        ROW_CMD,
        ROW_REG
    } row_kind_t;

    // one line of the directed stimulus: a command or a register write
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        cmd_t        cmd;
        bit          typed;
        drv_t        typed_drv;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bmbs_cmd_if cmd_ch ();
    bmbs_drv_if drv_ch ();

    brushed_motor_bridge_sequencer_top DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .drv     (drv_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the register file and of the sequencer state
    cfg_t   bridge_cfg;
    state_t bridge_st;

    // drive requests still owed by the block, oldest first
    drv_t pending_drives[$];

    row_t directed_rows[$];

    int mismatches  = 0;
    int cycle_count = 0;

    // command sender pacing
    int burst_left = 0;

    // random sequence shaping: speed sign segments and a running timestamp
    int          seg_left   = 0;
    int          seg_sign   = 1;
    logic [31:0] now_cursor = '0;

    // drive sink stall pattern
    int         rx_window = 0;
    int         rx_style  = 0;
    int         rx_phase  = 0;
    logic [7:0] rx_mask   = 8'hff;

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d drive requests outstanding",
                     cycle_count, pending_drives.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch %s: got %0d expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        mismatches++;
    endtask

    // --------------------------------------------------------------------
    // predictor: one command in, one drive request out, shadow state moves
    // --------------------------------------------------------------------
    function automatic drv_t bridge_step(input cmd_t c);
        drv_t        r;
        mode_t       want;
        int          spd;
        int          last;
        int          spd_mag;
        logic        zero_ish;
        logic [31:0] elapsed;
        r        = '0;
        spd      = $signed(c.speed_cmd);
        last     = $signed(bridge_st.prev_speed);
        spd_mag  = (spd < 0) ? -spd : spd;
        zero_ish = spd_mag < int'(bridge_cfg.zero_threshold);
        elapsed  = c.now_us - bridge_st.pause_start_us;
        if (!bridge_cfg.params_valid)
        begin
            // nothing moves but the missing-parameters flag
            bridge_st.err_no_params = 1'b1;
        end
        else
        begin
            bridge_st.err_no_params = 1'b0;
            want = bridge_st.mode;
            case (bridge_st.mode)
                MODE_STOP:
                    if (spd != 0)
                        want = MODE_RUN;
                MODE_RUN:
                    if (zero_ish)
                        want = MODE_STOP;
                    else if (((spd > 0 && last < 0) || (spd < 0 && last > 0)) &&
                             bridge_cfg.dead_time != '0)
                        want = MODE_PAUSE;
                MODE_PAUSE:
                    if (zero_ish)
                        want = MODE_STOP;
                    else if (elapsed >= 32'(bridge_cfg.dead_time))
                        want = MODE_RUN;
                default: ;
            endcase
            if (want != bridge_st.mode)
            begin
                bridge_st.pause_start_us = (want == MODE_RUN) ? '0 : c.now_us;
                bridge_st.mode           = want;
            end
            r.drive_valid = 1'b1;
            case (bridge_st.mode)
                MODE_STOP:
                    if (bridge_cfg.stop_drive == BRAKE_LOW)
                    begin
                        r.low_on_a = 1'b1;
                        r.low_on_b = 1'b1;
                    end
                    else if (bridge_cfg.stop_drive == BRAKE_HIGH)
                    begin
                        r.high_duty_a = FULL_DUTY;
                        r.high_duty_b = FULL_DUTY;
                    end
                MODE_RUN:
                    if (spd > 0)
                    begin
                        r.high_duty_a = DUTY_W'(spd);
                        r.low_on_b    = 1'b1;
                    end
                    else
                    begin
                        // zero speed lands here too; full negative saturates
                        r.low_on_a    = 1'b1;
                        r.high_duty_b = (spd_mag > int'(FULL_DUTY)) ? FULL_DUTY
                                                                    : DUTY_W'(spd_mag);
                    end
                default: ;
            endcase
            if (c.bridge_fault)
                bridge_st.err_bridge = 1'b1;
            else
            begin
                bridge_st.err_bridge = 1'b0;
                bridge_st.prev_speed = c.speed_cmd;
            end
        end
        r.mode_now       = bridge_st.mode;
        r.err_no_params  = bridge_st.err_no_params;
        r.err_bridge     = bridge_st.err_bridge;
        r.overall_status = (bridge_st.err_no_params || bridge_st.err_bridge) ? STATUS_ERROR
                                                                              : STATUS_OK;
        return r;
    endfunction

    task automatic compare_drive(input drv_t got, input drv_t want);
        if (got.drive_valid !== want.drive_valid)
            report_mismatch("drive_valid", got.drive_valid, want.drive_valid);
        if (got.high_duty_a !== want.high_duty_a)
            report_mismatch("high_duty_a", got.high_duty_a, want.high_duty_a);
        if (got.low_on_a !== want.low_on_a)
            report_mismatch("low_on_a", got.low_on_a, want.low_on_a);
        if (got.high_duty_b !== want.high_duty_b)
            report_mismatch("high_duty_b", got.high_duty_b, want.high_duty_b);
        if (got.low_on_b !== want.low_on_b)
            report_mismatch("low_on_b", got.low_on_b, want.low_on_b);
        if (got.mode_now !== want.mode_now)
            report_mismatch("mode_now", got.mode_now, want.mode_now);
        if (got.err_no_params !== want.err_no_params)
            report_mismatch("err_no_params", got.err_no_params, want.err_no_params);
        if (got.err_bridge !== want.err_bridge)
            report_mismatch("err_bridge", got.err_bridge, want.err_bridge);
        if (got.overall_status !== want.overall_status)
            report_mismatch("overall_status", got.overall_status, want.overall_status);
    endtask

    // --------------------------------------------------------------------
    // drive sink: the stall pattern is drawn anew for each random window:
    // always ready, a repeating 8-bit mask, three-in-four ready, long stalls
    // --------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_window == 0)
        begin
            rx_style  = $urandom_range(0, 3);
            rx_mask   = 8'($urandom) | 8'h01;
            rx_window = $urandom_range(50, 300);
        end
        rx_window--;
        case (rx_style)
            0:       drv_ch.ready = 1'b1;
            1:       drv_ch.ready = rx_mask[rx_phase % 8];
            2:       drv_ch.ready = ($urandom_range(0, 3) != 0);
            default: drv_ch.ready = (rx_phase % 32) < 12;
        endcase
        rx_phase++;
    end

    // every accepted drive request is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && drv_ch.valid && drv_ch.ready)
        begin
            if (pending_drives.size() == 0)
                report_mismatch("drive request with none pending", 32'd1, 32'd0);
            else
                compare_drive(drv_ch.payload, pending_drives.pop_front());
        end
    end

    // --------------------------------------------------------------------
    // command sender: bursts of random length, random gaps in between
    // --------------------------------------------------------------------
    task automatic send_cmd(input cmd_t c, input bit typed, input drv_t typed_drv);
        int   gap;
        drv_t pred;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                gap = $urandom_range(1, 6);
            else if ($urandom_range(0, 5) == 0)
                gap = $urandom_range(10, 25);
            else
                gap = 0;
            repeat (gap)
            begin
                @(negedge clk);
                cmd_ch.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 30);
        end
        @(negedge clk);
        cmd_ch.valid   = 1'b1;
        cmd_ch.payload = c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        // accepted: step the shadow model in acceptance order
        pred = bridge_step(c);
        pending_drives.push_back(typed ? typed_drv : pred);
        burst_left--;
    endtask

    // stop sending and let every owed drive request come out
    task automatic drain_requests();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    // apb write, then read back the same register
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (idx)
            REG_PARAMS_VALID:   bridge_cfg.params_valid   = val[0];
            REG_DEAD_TIME:      bridge_cfg.dead_time      = val[DEADTIME_W-1:0];
            REG_STOP_DRIVE:     bridge_cfg.stop_drive     = val[BRAKE_W-1:0];
            REG_ZERO_THRESHOLD: bridge_cfg.zero_threshold = val[THRESH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== val)
            report_mismatch("register readback", prdata, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic row_t cmd_row(input int spd, input logic [31:0] now, input bit fault);
        row_t r;
        r.kind              = ROW_CMD;
        r.reg_idx           = '0;
        r.reg_val           = '0;
        r.cmd.speed_cmd     = 16'(spd);
        r.cmd.now_us        = now;
        r.cmd.bridge_fault  = fault;
        r.typed             = 1'b0;
        r.typed_drv         = '0;
        return r;
    endfunction

    function automatic row_t cmd_row_exp(input int spd, input logic [31:0] now,
                                         input bit fault, input drv_t d);
        row_t r;
        r           = cmd_row(spd, now, fault);
        r.typed     = 1'b1;
        r.typed_drv = d;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
        row_t r;
        r         = cmd_row(0, '0, 1'b0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // speed sign holds for a short segment and then usually flips, so RUN
    // sees reversals; magnitudes cluster at the extremes and the threshold
    function automatic logic signed [SPEED_W-1:0] pick_speed();
        int mag_v;
        if (seg_left == 0)
        begin
            if ($urandom_range(0, 9) < 7)
                seg_sign = -seg_sign;
            seg_left = $urandom_range(1, 6);
        end
        seg_left--;
        case ($urandom_range(0, 9))
            0: mag_v = 32768;
            1: mag_v = int'(bridge_cfg.zero_threshold) - 1 + int'($urandom_range(0, 1));
            2: mag_v = 0;
            3: return SPEED_W'($urandom);
            default: mag_v = $urandom_range(1, 32767);
        endcase
        if (mag_v < 0)
            mag_v = 0;
        if (seg_sign > 0 && mag_v > 32767)
            mag_v = 32767;
        return SPEED_W'(seg_sign * mag_v);
    endfunction

    // time mostly creeps forward against the dead time; inside a pause it
    // sometimes lands right on the expiry edge, and now and then it jumps
    function automatic logic [31:0] pick_time();
        logic [31:0] dt32;
        dt32 = 32'(bridge_cfg.dead_time);
        case ($urandom_range(0, 11))
            0: now_cursor = $urandom;
            1, 2:
                if (bridge_st.mode == MODE_PAUSE)
                    now_cursor = bridge_st.pause_start_us + dt32 - 32'($urandom_range(0, 1));
                else
                    now_cursor += dt32;
            3: now_cursor += dt32 + 32'($urandom_range(0, 100));
            default: now_cursor += 32'($urandom_range(0, dt32 / 8 + 2));
        endcase
        return now_cursor;
    endfunction

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------
    initial
    begin
        logic                  pv;
        logic [DEADTIME_W-1:0] dt;
        logic [BRAKE_W-1:0]    bm;
        logic [THRESH_W-1:0]   thr;
        cmd_t                  c;

        // every block input known from time zero
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        drv_ch.ready   = 1'b0;

        // shadow state after reset: registers zero but the threshold at 1
        bridge_cfg                = '0;
        bridge_cfg.zero_threshold = THRESH_W'(1);
        bridge_st                 = '0;
        bridge_st.mode            = MODE_STOP;

        // directed walk; typed rows carry a hand-derived drive request
        // fields: valid, duty a, low a, duty b, low b, mode, no-params, bridge, status
        directed_rows = '{
            // unconfigured: error flags only, fault does not touch err_bridge
            cmd_row_exp(100, 32'd0, 1'b0,
                drv_t'{1'b0, 15'd0, 1'b0, 15'd0, 1'b0, MODE_STOP, 1'b1, 1'b0, STATUS_ERROR}),
            cmd_row_exp(-32768, 32'hffff_ffff, 1'b1,
                drv_t'{1'b0, 15'd0, 1'b0, 15'd0, 1'b0, MODE_STOP, 1'b1, 1'b0, STATUS_ERROR}),
            reg_row(REG_PARAMS_VALID, 32'd1),
            reg_row(REG_STOP_DRIVE, 32'(BRAKE_LOW)),
            // stop with low-side brake
            cmd_row_exp(0, 32'd10, 1'b0,
                drv_t'{1'b1, 15'd0, 1'b1, 15'd0, 1'b1, MODE_STOP, 1'b0, 1'b0, STATUS_OK}),
            // full forward, then full reverse saturating; no dead time yet
            cmd_row_exp(32767, 32'd20, 1'b0,
                drv_t'{1'b1, FULL_DUTY, 1'b0, 15'd0, 1'b1, MODE_RUN, 1'b0, 1'b0, STATUS_OK}),
            cmd_row_exp(-32768, 32'd30, 1'b0,
                drv_t'{1'b1, 15'd0, 1'b1, FULL_DUTY, 1'b0, MODE_RUN, 1'b0, 1'b0, STATUS_OK}),
            // bridge fault: flag set, last speed kept at full reverse
            cmd_row_exp(-1, 32'd40, 1'b1,
                drv_t'{1'b1, 15'd0, 1'b1, 15'd1, 1'b0, MODE_RUN, 1'b0, 1'b1, STATUS_ERROR}),
            cmd_row_exp(5, 32'd50, 1'b0,
                drv_t'{1'b1, 15'd5, 1'b0, 15'd0, 1'b1, MODE_RUN, 1'b0, 1'b0, STATUS_OK}),
            reg_row(REG_DEAD_TIME, 32'd1_000_000),
            // reversal with dead time: bridge floats
            cmd_row_exp(-5, 32'd60, 1'b0,
                drv_t'{1'b1, 15'd0, 1'b0, 15'd0, 1'b0, MODE_PAUSE, 1'b0, 1'b0, STATUS_OK}),
            // one microsecond short, then exactly on the dead time
            cmd_row(-7, 32'd1_000_059, 1'b0),
            cmd_row(-7, 32'd1_000_060, 1'b0),
            // pause started near the top of the time range, expiry after wrap
            cmd_row(9, 32'hffff_fff0, 1'b0),
            cmd_row(9, 32'd999_983, 1'b0),
            cmd_row(9, 32'd999_984, 1'b0),
            cmd_row(0, 32'd1_000_000, 1'b0),
            reg_row(REG_STOP_DRIVE, 32'(BRAKE_HIGH)),
            cmd_row_exp(0, 32'd1_000_010, 1'b0,
                drv_t'{1'b1, FULL_DUTY, 1'b0, FULL_DUTY, 1'b0, MODE_STOP, 1'b0, 1'b0, STATUS_OK}),
            // brake code three coasts; fault in stop
            reg_row(REG_STOP_DRIVE, 32'(BRAKE_UNUSED)),
            cmd_row_exp(0, 32'd1_000_020, 1'b1,
                drv_t'{1'b1, 15'd0, 1'b0, 15'd0, 1'b0, MODE_STOP, 1'b0, 1'b1, STATUS_ERROR}),
            // zero threshold: a zero speed stays in run on the reverse branch
            reg_row(REG_ZERO_THRESHOLD, 32'd0),
            cmd_row(1, 32'd1_000_030, 1'b0),
            cmd_row(0, 32'd1_000_040, 1'b0),
            // top threshold: in run and pause only magnitude 32767 or more counts as moving
            reg_row(REG_ZERO_THRESHOLD, 32'd32767),
            cmd_row(32766, 32'd1_000_050, 1'b0),
            cmd_row(-32768, 32'd1_000_060, 1'b0),
            cmd_row(32767, 32'd1_000_070, 1'b0),
            cmd_row(-100, 32'd1_000_080, 1'b0),
            // parameters withdrawn: drive off, mode held
            reg_row(REG_PARAMS_VALID, 32'd0),
            cmd_row_exp(7, 32'd1_000_090, 1'b1,
                drv_t'{1'b0, 15'd0, 1'b0, 15'd0, 1'b0, MODE_STOP, 1'b1, 1'b0, STATUS_ERROR})
        };

        // reset held from time zero, released on a falling edge
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                drain_requests();
                set_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_cmd(directed_rows[i].cmd, directed_rows[i].typed,
                         directed_rows[i].typed_drv);
        end

        // random phases; the first two pin the register extremes, the third a fixed setting
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    pv = 1'b1; dt = '0; bm = BRAKE_COAST; thr = '0;
                end
                1:
                begin
                    pv = 1'b1; dt = '1; bm = BRAKE_UNUSED; thr = '1;
                end
                2:
                begin
                    pv = 1'b1; dt = DEADTIME_W'(1_000_000); bm = BRAKE_HIGH; thr = 15'd1;
                end
                default:
                begin
                    pv = ($urandom_range(0, 7) != 0);
                    case ($urandom_range(0, 4))
                        0:       dt = '0;
                        1:       dt = DEADTIME_W'($urandom_range(1, 8));
                        2:       dt = DEADTIME_W'($urandom_range(9, 200));
                        3:       dt = DEADTIME_W'($urandom);
                        default: dt = DEADTIME_W'(1_000_000);
                    endcase
                    bm = BRAKE_W'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0:       thr = '0;
                        1:       thr = 15'd1;
                        2:       thr = THRESH_W'($urandom_range(2, 64));
                        default: thr = THRESH_W'($urandom);
                    endcase
                end
            endcase
            drain_requests();
            set_reg(REG_PARAMS_VALID, 32'(pv));
            set_reg(REG_DEAD_TIME, 32'(dt));
            set_reg(REG_STOP_DRIVE, 32'(bm));
            set_reg(REG_ZERO_THRESHOLD, 32'(thr));

            // start some phases just below the wrap point of the timer
            if ($urandom_range(0, 2) == 0)
                now_cursor = 32'hffff_ffff - 32'($urandom_range(0, 5000));
            else
                now_cursor = $urandom;

            repeat (ITEMS_PER_PHASE)
            begin
                c.speed_cmd    = pick_speed();
                c.now_us       = pick_time();
                c.bridge_fault = ($urandom_range(0, 9) == 0);
                send_cmd(c, 1'b0, '0);
            end
        end

        // everything sent: wait out the owed requests and a short tail
        drain_requests();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bmbs_pkg.sv
hw/rtl/bmbs_cmd_if.sv
hw/rtl/bmbs_drv_if.sv
hw/rtl/bmbs_step.sv
hw/rtl/brushed_motor_bridge_sequencer_top.sv
dv/brushed_motor_bridge_sequencer_top_test.sv
